[hw/rtl/lcwe_pkg.sv]
`timescale 1ns / 1ps

package lcwe_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_WIDTH  = 8;
    localparam int MIN_HEIGHT = 1;

    localparam int COORD_W = 10;   // column / row coordinate
    localparam int SIZE_W  = 11;   // width / height register
    localparam int ERR_W   = 11;   // frame error result
    localparam int WSUM_W  = 32;   // weighted error total
    localparam int WT_W    = 20;   // weight total
    localparam int PROD_W  = 23;   // (half - center) * (row + 1)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_FIRST_SCAN_ROW = 2'd2;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH    = 11'd640;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT   = 11'd280;
    localparam logic [COORD_W-1:0] RST_FIRST_SCAN_ROW = 10'd200;

    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [COORD_W-1:0] first_scan_row;
    } cfg_t;

    // One finished row handed from the pixel front end to the back end
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] center;
        logic [COORD_W-1:0] half;
        logic               scanned;
        logic               last;
    } row_rec_t;

endpackage

[hw/rtl/lcwe_front.sv]
`timescale 1ns / 1ps

module lcwe_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcwe_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   pixel_on,
    output logic                   push,
    output lcwe_pkg::row_rec_t     push_rec
);

    logic [lcwe_pkg::COORD_W-1:0] col_reg, col_next;
    logic [lcwe_pkg::COORD_W-1:0] row_reg, row_next;
    logic [1:0]                   prev_reg, prev_next;
    logic [lcwe_pkg::COORD_W-1:0] left_reg, left_next;
    logic [lcwe_pkg::COORD_W-1:0] right_reg, right_next;
    logic                         rfound_reg, rfound_next;

    logic [lcwe_pkg::SIZE_W-1:0]  w_eff, h_eff, half11, x11, w_m1, h_m1;
    logic [lcwe_pkg::SIZE_W-1:0]  edge_sum;
    logic [lcwe_pkg::COORD_W-1:0] right_sel;
    logic                         accept, row_end, scanned, last;

    always_comb
    begin
        if (cfg.image_width < lcwe_pkg::SIZE_W'(lcwe_pkg::MIN_WIDTH))
            w_eff = lcwe_pkg::SIZE_W'(lcwe_pkg::MIN_WIDTH);
        else if (cfg.image_width > lcwe_pkg::SIZE_W'(lcwe_pkg::MAX_WIDTH))
            w_eff = lcwe_pkg::SIZE_W'(lcwe_pkg::MAX_WIDTH);
        else
            w_eff = cfg.image_width;
        if (cfg.image_height < lcwe_pkg::SIZE_W'(lcwe_pkg::MIN_HEIGHT))
            h_eff = lcwe_pkg::SIZE_W'(lcwe_pkg::MIN_HEIGHT);
        else if (cfg.image_height > lcwe_pkg::SIZE_W'(lcwe_pkg::MAX_HEIGHT))
            h_eff = lcwe_pkg::SIZE_W'(lcwe_pkg::MAX_HEIGHT);
        else
            h_eff = cfg.image_height;
    end

    assign half11 = {1'b0, w_eff[lcwe_pkg::SIZE_W-1:1]};
    assign w_m1   = w_eff - 11'd1;
    assign h_m1   = h_eff - 11'd1;
    assign x11    = {1'b0, col_reg};
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        left_next   = left_reg;
        right_next  = right_reg;
        rfound_next = rfound_reg;
        // left edge: 0,0,1 ending at x, last hit wins
        if (x11 >= 11'd2 && x11 + 11'd1 <= half11 && pixel_on && prev_reg == 2'b00)
            left_next = col_reg;
        // right edge: 1,0,0 starting at x-2, first hit wins
        if (!rfound_reg && x11 >= half11 + 11'd2 && x11 <= w_m1 &&
            !pixel_on && prev_reg == 2'b10)
        begin
            right_next  = col_reg - 10'd2;
            rfound_next = 1'b1;
        end
    end

    assign row_end   = x11 >= w_m1;
    assign right_sel = rfound_next ? right_next : w_m1[lcwe_pkg::COORD_W-1:0];
    assign edge_sum  = {1'b0, left_next} + {1'b0, right_sel};
    assign scanned   = row_reg >= cfg.first_scan_row;
    assign last      = {1'b0, row_reg} >= h_m1;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        prev_next = prev_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next  = '0;
                prev_next = '0;
                row_next  = last ? '0 : row_reg + 10'd1;
            end
            else
            begin
                col_next  = col_reg + 10'd1;
                prev_next = {prev_reg[0], pixel_on};
            end
        end
    end

    assign push             = accept && row_end && (scanned || last);
    assign push_rec.row     = row_reg;
    assign push_rec.center  = edge_sum[lcwe_pkg::SIZE_W-1:1];
    assign push_rec.half    = half11[lcwe_pkg::COORD_W-1:0];
    assign push_rec.scanned = scanned;
    assign push_rec.last    = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            prev_reg   <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            rfound_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            prev_reg <= prev_next;
            if (accept)
            begin
                if (row_end)
                begin
                    left_reg   <= '0;
                    right_reg  <= '0;
                    rfound_reg <= 1'b0;
                end
                else
                begin
                    left_reg   <= left_next;
                    right_reg  <= right_next;
                    rfound_reg <= rfound_next;
                end
            end
        end
    end

endmodule

[hw/rtl/lcwe_fifo.sv]
`timescale 1ns / 1ps

module lcwe_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lcwe_pkg::row_rec_t push_rec,
    input  logic               pop,
    output lcwe_pkg::row_rec_t head_rec,
    output logic               empty,
    output logic               full
);

    lcwe_pkg::row_rec_t            entry_reg [lcwe_pkg::FIFO_DEPTH];
    logic [lcwe_pkg::FIFO_AW-1:0]  wptr_reg, rptr_reg;
    logic [lcwe_pkg::FIFO_AW:0]    count_reg;
    logic                          do_push, do_pop;

    assign empty    = count_reg == '0;
    assign full     = count_reg == (lcwe_pkg::FIFO_AW+1)'(lcwe_pkg::FIFO_DEPTH);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[hw/rtl/lcwe_back.sv]
`timescale 1ns / 1ps

module lcwe_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lcwe_pkg::row_rec_t                  head_rec,
    input  logic                                empty,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lcwe_pkg::COORD_W-1:0]        row_index,
    output logic [lcwe_pkg::COORD_W-1:0]        row_center,
    output logic signed [lcwe_pkg::ERR_W-1:0]   frame_error,
    output logic                                frame_done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_DINIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIX   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                               state_reg;
    lcwe_pkg::row_rec_t                       rec_reg;
    logic signed [lcwe_pkg::PROD_W-1:0]       prod_reg;
    logic signed [lcwe_pkg::WSUM_W-1:0]       wsum_reg;
    logic [lcwe_pkg::WT_W-1:0]                wt_reg;
    logic [lcwe_pkg::WSUM_W-1:0]              quo_reg;
    logic [lcwe_pkg::WT_W:0]                  rem_reg;
    logic                                     neg_reg;
    logic [$clog2(lcwe_pkg::WSUM_W)-1:0]      step_reg;
    logic signed [lcwe_pkg::ERR_W-1:0]        err_reg;

    logic                                     out_valid_reg;
    logic [lcwe_pkg::COORD_W-1:0]             out_row_reg, out_center_reg;
    logic signed [lcwe_pkg::ERR_W-1:0]        out_err_reg;
    logic                                     out_done_reg;

    logic signed [lcwe_pkg::SIZE_W-1:0]       diff;
    logic [lcwe_pkg::SIZE_W-1:0]              weight;
    logic signed [lcwe_pkg::PROD_W-1:0]       prod;
    logic [lcwe_pkg::WT_W:0]                  rem_shift;
    logic                                     rem_ge;
    logic [lcwe_pkg::WSUM_W-1:0]              wsum_mag;

    assign pop    = (state_reg == S_IDLE) && !empty && !out_valid_reg;
    assign diff   = $signed({1'b0, rec_reg.half}) - $signed({1'b0, rec_reg.center});
    assign weight = {1'b0, rec_reg.row} + 11'd1;
    // signed product, both operands sign-extended to the product width
    assign prod   = diff * $signed({1'b0, weight});

    // restoring divide, one quotient bit per cycle
    assign rem_shift = {rem_reg[lcwe_pkg::WT_W-1:0], quo_reg[lcwe_pkg::WSUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, wt_reg};
    assign wsum_mag  = wsum_reg[lcwe_pkg::WSUM_W-1] ? -wsum_reg : wsum_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= head_rec;
        if (state_reg == S_MUL)
            prod_reg <= rec_reg.scanned ? prod : '0;
        if (state_reg == S_DINIT)
        begin
            quo_reg <= wsum_mag;
            rem_reg <= '0;
            neg_reg <= wsum_reg[lcwe_pkg::WSUM_W-1];
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= rem_ge ? rem_shift - {1'b0, wt_reg} : rem_shift;
            quo_reg <= {quo_reg[lcwe_pkg::WSUM_W-2:0], rem_ge};
        end
        if (state_reg == S_DINIT)
            err_reg <= '0;
        else if (state_reg == S_FIX)
            err_reg <= neg_reg ? -$signed(quo_reg[lcwe_pkg::ERR_W-1:0])
                               : $signed(quo_reg[lcwe_pkg::ERR_W-1:0]);
        if (state_reg == S_OUT)
        begin
            out_row_reg    <= rec_reg.row;
            out_center_reg <= rec_reg.center;
            out_err_reg    <= rec_reg.last ? err_reg : '0;
            out_done_reg   <= rec_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wsum_reg      <= '0;
            wt_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    wsum_reg  <= wsum_reg + lcwe_pkg::WSUM_W'(prod_reg);
                    if (rec_reg.scanned)
                        wt_reg <= wt_reg + lcwe_pkg::WT_W'(weight);
                    state_reg <= rec_reg.last ? S_DINIT : S_OUT;
                end
                S_DINIT:
                begin
                    step_reg  <= '0;
                    state_reg <= (wt_reg == '0) ? S_OUT : S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == '1)
                        state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (rec_reg.last)
                    begin
                        wsum_reg <= '0;
                        wt_reg   <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_index   = out_row_reg;
    assign row_center  = out_center_reg;
    assign frame_error = out_err_reg;
    assign frame_done  = out_done_reg;

endmodule

[hw/rtl/lane_center_weighted_error_core.sv]
`timescale 1ns / 1ps
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------------------
// pixel in | in_valid / in_stall | pixel_on
// row out  | out_valid/out_stall | row_index, row_center, frame_error, frame_done
// config   | cfg_write           | cfg_index, cfg_data
//
// One pixel item per cycle; in_stall rises only when the 4-entry row queue
// is full. Each row record passes through the back end in these steps: pop,
// multiply, accumulate, output, hand-off; the next record is popped only once
// its result is taken. The last row of a frame adds setup, a 32-step serial
// divide and a sign fix, or setup alone when no row of the frame was weighted.
// Reset (async, rst_n low) clears counters, totals, queue and output valid;
// config returns to 640 x 280, first scanned row 200.
// A waiting result never blocks pixel intake until the queue fills.

module lane_center_weighted_error_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [lcwe_pkg::SIZE_W-1:0]         cfg_data,
    // pixel stream
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                pixel_on,
    // row results
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lcwe_pkg::COORD_W-1:0]        row_index,
    output logic [lcwe_pkg::COORD_W-1:0]        row_center,
    output logic signed [lcwe_pkg::ERR_W-1:0]   frame_error,
    output logic                                frame_done
);

    lcwe_pkg::cfg_t     cfg_reg;
    lcwe_pkg::row_rec_t push_rec, head_rec;
    logic               push, pop, q_empty, q_full;

    // config register file; out-of-list indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= lcwe_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height   <= lcwe_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.first_scan_row <= lcwe_pkg::RST_FIRST_SCAN_ROW;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lcwe_pkg::REG_IMAGE_WIDTH:    cfg_reg.image_width  <= cfg_data;
                lcwe_pkg::REG_IMAGE_HEIGHT:   cfg_reg.image_height <= cfg_data;
                lcwe_pkg::REG_FIRST_SCAN_ROW:
                    cfg_reg.first_scan_row <= cfg_data[lcwe_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // stall on a full queue so a row-end pixel always finds room
    assign in_stall = q_full;

    // front: column/row counting, edge search, row center
    lcwe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pixel_on (pixel_on),
        .push     (push),
        .push_rec (push_rec)
    );

    lcwe_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: weighted totals, frame divide, output register
    lcwe_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_rec    (head_rec),
        .empty       (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_index   (row_index),
        .row_center  (row_center),
        .frame_error (frame_error),
        .frame_done  (frame_done)
    );

endmodule

[hw/rtl/lcwe_checker.sv]
`timescale 1ns / 1ps

module lcwe_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [lcwe_pkg::COORD_W-1:0]        row_index,
    input  logic [lcwe_pkg::COORD_W-1:0]        row_center,
    input  logic signed [lcwe_pkg::ERR_W-1:0]   frame_error,
    input  logic                                frame_done
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_index) &&
        $stable(row_center) && $stable(frame_error) && $stable(frame_done))
        else $error("result changed while stalled");

    // error only carried on the frame's last row
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> frame_error == '0)
        else $error("nonzero error on a mid-frame row");

    // a new row is popped only after the last result is taken, so no back-to-back results
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result right after a taken result");

    // an edge seen in reset leaves the output empty at the next edge
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind lane_center_weighted_error_core lcwe_checker u_lcwe_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .row_index   (row_index),
    .row_center  (row_center),
    .frame_error (frame_error),
    .frame_done  (frame_done)
);
